@@ rtl/fssw_pkg.sv @@
// ----------------------------------------------------------------------------
// fssw_pkg
// Shared constants, codes, microcode format and microprogram for the flash
// sector staging writer.
// ----------------------------------------------------------------------------
package fssw_pkg;

  localparam int unsigned SECTOR_BYTES = 4096;
  localparam int unsigned PAGE_BYTES   = 256;
  localparam int unsigned REGION_BYTES = 1048576;
  localparam int unsigned REGIONS      = 2;

  localparam int unsigned REQ_W      = 3;
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned REGION_W   = 1;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned ADDR_W     = 21;
  localparam int unsigned TOTAL_W    = 21;
  localparam int unsigned SECTOR_W   = 9;
  localparam int unsigned FILL_W     = $clog2(SECTOR_BYTES);
  localparam int unsigned COUNT_W    = FILL_W + 1;
  localparam int unsigned PAGE_SH    = $clog2(PAGE_BYTES);
  localparam int unsigned REGION_SH  = $clog2(REGION_BYTES);
  localparam int unsigned PAGE_IDX_W = $clog2(SECTOR_BYTES / PAGE_BYTES) + 1;
  localparam int unsigned MEM_AW     = REGION_W + FILL_W;
  localparam int unsigned MEM_DEPTH  = REGIONS * SECTOR_BYTES;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_WRITE   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_FLUSH   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_READ    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_SETSIZE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd4;

  typedef enum logic [CMD_W-1:0] {
    CMD_ACK   = 3'd0,
    CMD_WREN  = 3'd1,
    CMD_ERASE = 3'd2,
    CMD_PROG  = 3'd3,
    CMD_READ  = 3'd4
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE, S_WR, S_FLUSH, S_READ, S_SETSZ, S_CLEAR,
    S_ACK, S_ACK_NODATA, S_RDCMD, S_ERASE, S_WREN, S_PROG
  } step_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LATCH, OP_WRITE, OP_FLUSH, OP_READ,
    OP_SETSIZE, OP_CLEAR, OP_PAGE_CLR, OP_PAGE_ADV
  } op_t;

  typedef enum logic [2:0] {
    COND_NONE, COND_DISPATCH, COND_FULL, COND_FILL_ZERO, COND_NODATA, COND_PAGE_LAST
  } cond_t;

  typedef enum logic [1:0] {ASEL_ZERO, ASEL_SECTOR, ASEL_PAGE} addr_sel_t;
  typedef enum logic [1:0] {CSEL_ZERO, CSEL_READ, CSEL_PAGE} count_sel_t;
  typedef enum logic [1:0] {LAST_NO, LAST_YES, LAST_PAGE} last_sel_t;

  typedef struct packed {
    logic       wait_in;
    logic       emit;
    cmd_t       cmd;
    logic       status;
    addr_sel_t  asel;
    count_sel_t csel;
    last_sel_t  lsel;
    op_t        op;
    cond_t      cond;
    step_t      jump;
    step_t      next;
  } uword_t;

  // Datapath tests seen by the sequencer
  typedef struct packed {
    logic full;
    logic fill_zero;
    logic nodata;
    logic page_last;
  } flags_t;

  // Current control word and whether its step executes this cycle
  typedef struct packed {
    uword_t uw;
    logic   fire;
  } exec_t;

  function automatic step_t entry(logic [REQ_W-1:0] r);
    step_t s;
    case (r)
      REQ_WRITE:   s = S_WR;
      REQ_FLUSH:   s = S_FLUSH;
      REQ_READ:    s = S_READ;
      REQ_SETSIZE: s = S_SETSZ;
      REQ_CLEAR:   s = S_CLEAR;
      default:     s = S_ACK;
    endcase
    return s;
  endfunction

  // Microprogram ROM
  function automatic uword_t ucode(step_t s);
    uword_t w;
    w = '0;
    case (s)
      S_IDLE: begin
        w.wait_in = 1'b1;
        w.op      = OP_LATCH;
        w.cond    = COND_DISPATCH;
        w.next    = S_IDLE;
      end
      S_WR: begin
        w.op   = OP_WRITE;
        w.cond = COND_FULL;
        w.jump = S_ERASE;
        w.next = S_ACK;
      end
      S_FLUSH: begin
        w.op   = OP_FLUSH;
        w.cond = COND_FILL_ZERO;
        w.jump = S_ACK;
        w.next = S_ERASE;
      end
      S_READ: begin
        w.op   = OP_READ;
        w.cond = COND_NODATA;
        w.jump = S_ACK_NODATA;
        w.next = S_RDCMD;
      end
      S_SETSZ: begin
        w.op   = OP_SETSIZE;
        w.next = S_ACK;
      end
      S_CLEAR: begin
        w.op   = OP_CLEAR;
        w.next = S_ACK;
      end
      S_ACK: begin
        w.emit = 1'b1;
        w.cmd  = CMD_ACK;
        w.lsel = LAST_YES;
        w.next = S_IDLE;
      end
      S_ACK_NODATA: begin
        w.emit   = 1'b1;
        w.cmd    = CMD_ACK;
        w.status = 1'b1;
        w.lsel   = LAST_YES;
        w.next   = S_IDLE;
      end
      S_RDCMD: begin
        w.emit = 1'b1;
        w.cmd  = CMD_READ;
        w.asel = ASEL_SECTOR;
        w.csel = CSEL_READ;
        w.lsel = LAST_YES;
        w.next = S_IDLE;
      end
      S_ERASE: begin
        w.emit = 1'b1;
        w.cmd  = CMD_ERASE;
        w.asel = ASEL_SECTOR;
        w.op   = OP_PAGE_CLR;
        w.next = S_WREN;
      end
      S_WREN: begin
        w.emit = 1'b1;
        w.cmd  = CMD_WREN;
        w.next = S_PROG;
      end
      S_PROG: begin
        w.emit = 1'b1;
        w.cmd  = CMD_PROG;
        w.asel = ASEL_PAGE;
        w.csel = CSEL_PAGE;
        w.lsel = LAST_PAGE;
        w.op   = OP_PAGE_ADV;
        w.cond = COND_PAGE_LAST;
        w.jump = S_IDLE;
        w.next = S_PROG;
      end
      default: begin
        w.next = S_IDLE;
      end
    endcase
    return w;
  endfunction

  // region * REGION_BYTES + sector * SECTOR_BYTES + offset, wrapped
  function automatic logic [ADDR_W-1:0] flash_addr(logic [REGION_W-1:0] rg,
                                                   logic [SECTOR_W-1:0] sector,
                                                   logic [FILL_W-1:0] off);
    return (ADDR_W'(rg) << REGION_SH) + (ADDR_W'(sector) << FILL_W) + ADDR_W'(off);
  endfunction

endpackage

@@ rtl/fssw_if.sv @@
// ----------------------------------------------------------------------------
// fssw_req_if / fssw_rsp_if
// Valid/ready channels for requests and for flash command results.
// ----------------------------------------------------------------------------
interface fssw_req_if;
  logic                             valid;
  logic                             ready;
  logic [fssw_pkg::REQ_W-1:0]       req_type;
  logic [fssw_pkg::REGION_W-1:0]    region;
  logic [fssw_pkg::BYTE_W-1:0]      data_byte;
  logic [fssw_pkg::TOTAL_W-1:0]     stored_size;

  modport source(output valid, req_type, region, data_byte, stored_size, input ready);
  modport sink(input valid, req_type, region, data_byte, stored_size, output ready);
endinterface

interface fssw_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [fssw_pkg::CMD_W-1:0]       cmd;
  logic [fssw_pkg::ADDR_W-1:0]      flash_addr;
  logic [fssw_pkg::COUNT_W-1:0]     byte_count;
  logic [fssw_pkg::FILL_W-1:0]      buffer_offset;
  logic                             status;
  logic [fssw_pkg::TOTAL_W-1:0]     region_total;
  logic                             last;

  modport source(output valid, cmd, flash_addr, byte_count, buffer_offset, status,
                 region_total, last, input ready);
  modport sink(input valid, cmd, flash_addr, byte_count, buffer_offset, status,
               region_total, last, output ready);
endinterface

@@ rtl/flash_sector_staging_writer.sv @@
// ----------------------------------------------------------------------------
// flash_sector_staging_writer
// Stages bytes per flash region and emits the erase, write-enable, program
// and read commands that commit and fetch them.
// ----------------------------------------------------------------------------
// Each request transfer yields one or more result transfers, the final one
// marked by last. A request that commits nothing (write byte that does not
// fill the sector, set size, clear, read, empty flush) takes three sequencer
// steps: accept, update, report. A sector commit (the byte that fills the
// sector, or a flush of a partial sector) takes 2 + N + 2 steps, where N is
// the number of program commands (up to 16 for a full sector): accept,
// update, erase, write enable, then one program command per page, the last
// one short when the fill is not a whole number of pages. The sequencer runs
// one microcode step per clock, but the accept step waits for a request and
// every result step waits while the single output register still holds an
// untaken result. A new request is taken as soon as the sequencer is back
// at its accept step, even if the previous one's final result is untaken.
// ----------------------------------------------------------------------------
module flash_sector_staging_writer (
  input  logic        clk,
  input  logic        rst,
  fssw_req_if.sink    req,
  fssw_rsp_if.source  rsp
);

  fssw_pkg::exec_t  ex;
  fssw_pkg::flags_t flags;
  logic             out_free;

  // Sequencer: step counter, microcode ROM and branch selection
  fssw_useq u_useq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (req.valid),
    .in_req_type (req.req_type),
    .flags       (flags),
    .out_free    (out_free),
    .ex          (ex),
    .in_ready    (req.ready)
  );

  // Datapath: cursors per region, staging memory, result register
  fssw_dpath u_dpath (
    .clk               (clk),
    .rst               (rst),
    .ex                (ex),
    .in_region         (req.region),
    .in_data_byte      (req.data_byte),
    .in_stored_size    (req.stored_size),
    .out_ready         (rsp.ready),
    .flags             (flags),
    .out_free          (out_free),
    .out_valid         (rsp.valid),
    .out_cmd           (rsp.cmd),
    .out_flash_addr    (rsp.flash_addr),
    .out_byte_count    (rsp.byte_count),
    .out_buffer_offset (rsp.buffer_offset),
    .out_status        (rsp.status),
    .out_region_total  (rsp.region_total),
    .out_last          (rsp.last)
  );

  // The sequencer leaves its accept step right after a request transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted twice in a row");

  // Program commands carry between one byte and one page
  a_prog_count: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.cmd == fssw_pkg::CMD_PROG) |->
      (rsp.byte_count != '0 &&
       rsp.byte_count <= fssw_pkg::COUNT_W'(fssw_pkg::PAGE_BYTES)))
    else $error("program byte count out of range");

  // No-data status only on a final acknowledge
  a_nodata_ack: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status) |-> (rsp.cmd == fssw_pkg::CMD_ACK && rsp.last))
    else $error("no-data status on a non-final or non-ack result");

  // Erase and write enable always precede program commands
  a_commit_not_last: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.cmd == fssw_pkg::CMD_ERASE || rsp.cmd == fssw_pkg::CMD_WREN))
      |-> !rsp.last)
    else $error("commit sequence ended before programming");

endmodule

@@ rtl/fssw_useq.sv @@
// ----------------------------------------------------------------------------
// fssw_useq
// Step counter and microcode ROM; picks the next step from the control word.
// ----------------------------------------------------------------------------
module fssw_useq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [fssw_pkg::REQ_W-1:0]  in_req_type,
  input  fssw_pkg::flags_t            flags,
  input  logic                        out_free,
  output fssw_pkg::exec_t             ex,
  output logic                        in_ready
);

  fssw_pkg::step_t  pc;
  fssw_pkg::step_t  pc_next;
  fssw_pkg::uword_t uw;
  logic             fire;
  logic             hit;

  assign uw = fssw_pkg::ucode(pc);

  always_comb begin
    case (uw.cond)
      fssw_pkg::COND_FULL:      hit = flags.full;
      fssw_pkg::COND_FILL_ZERO: hit = flags.fill_zero;
      fssw_pkg::COND_NODATA:    hit = flags.nodata;
      fssw_pkg::COND_PAGE_LAST: hit = flags.page_last;
      default:                  hit = 1'b0;
    endcase
  end

  // A waiting step needs a transfer in; an emitting step needs room at the output
  always_comb begin
    if (uw.wait_in) begin
      fire = in_valid;
    end else if (uw.emit) begin
      fire = out_free;
    end else begin
      fire = 1'b1;
    end
  end

  always_comb begin
    if (!fire) begin
      pc_next = pc;
    end else if (uw.cond == fssw_pkg::COND_DISPATCH) begin
      pc_next = fssw_pkg::entry(in_req_type);
    end else if (hit) begin
      pc_next = uw.jump;
    end else begin
      pc_next = uw.next;
    end
  end

  always_comb begin
    ex.uw    = uw;
    ex.fire  = fire;
    in_ready = uw.wait_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= fssw_pkg::S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

@@ rtl/fssw_dpath.sv @@
// ----------------------------------------------------------------------------
// fssw_dpath
// Region cursors, staging buffer, work registers and the result register.
// ----------------------------------------------------------------------------
module fssw_dpath (
  input  logic                           clk,
  input  logic                           rst,
  input  fssw_pkg::exec_t                ex,
  input  logic [fssw_pkg::REGION_W-1:0]  in_region,
  input  logic [fssw_pkg::BYTE_W-1:0]    in_data_byte,
  input  logic [fssw_pkg::TOTAL_W-1:0]   in_stored_size,
  input  logic                           out_ready,
  output fssw_pkg::flags_t               flags,
  output logic                           out_free,
  output logic                           out_valid,
  output logic [fssw_pkg::CMD_W-1:0]     out_cmd,
  output logic [fssw_pkg::ADDR_W-1:0]    out_flash_addr,
  output logic [fssw_pkg::COUNT_W-1:0]   out_byte_count,
  output logic [fssw_pkg::FILL_W-1:0]    out_buffer_offset,
  output logic                           out_status,
  output logic [fssw_pkg::TOTAL_W-1:0]   out_region_total,
  output logic                           out_last
);

  localparam int unsigned TW = fssw_pkg::TOTAL_W;
  localparam int unsigned SW = fssw_pkg::SECTOR_W;
  localparam int unsigned FW = fssw_pkg::FILL_W;
  localparam int unsigned CW = fssw_pkg::COUNT_W;
  localparam int unsigned PW = fssw_pkg::PAGE_IDX_W;

  logic [TW-1:0] committed_total [fssw_pkg::REGIONS];
  logic [SW-1:0] write_sector    [fssw_pkg::REGIONS];
  logic [FW-1:0] buffer_fill     [fssw_pkg::REGIONS];
  logic [TW-1:0] read_total      [fssw_pkg::REGIONS];
  logic [SW-1:0] read_sector     [fssw_pkg::REGIONS];

  logic [fssw_pkg::BYTE_W-1:0] staging_buffer [fssw_pkg::MEM_DEPTH];

  logic [fssw_pkg::REGION_W-1:0] rg;
  logic [fssw_pkg::BYTE_W-1:0]   byte_q;
  logic [TW-1:0]                 size_q;
  logic [SW-1:0]                 wk_sector;
  logic [CW-1:0]                 wk_fill;
  logic [CW-1:0]                 wk_count;
  logic [PW-1:0]                 wk_page;

  logic [FW-1:0] cur_fill;
  logic [TW-1:0] cur_total;
  logic [TW-1:0] cur_rtotal;
  logic          sector_ahead;
  logic [TW-1:0] read_diff;
  logic [CW-1:0] read_cnt;
  logic [CW-1:0] page_base;
  logic [CW-1:0] remaining;
  logic [CW-1:0] page_cnt;
  logic          fire;
  fssw_pkg::op_t op;

  assign fire = ex.fire;
  assign op   = ex.uw.op;

  always_comb begin
    cur_fill     = buffer_fill[rg];
    cur_total    = committed_total[rg];
    cur_rtotal   = read_total[rg];
    sector_ahead = write_sector[rg] > read_sector[rg];
    read_diff    = cur_total - cur_rtotal;
    if (sector_ahead || read_diff > TW'(fssw_pkg::SECTOR_BYTES)) begin
      read_cnt = CW'(fssw_pkg::SECTOR_BYTES);
    end else begin
      read_cnt = read_diff[CW-1:0];
    end
    page_base = CW'(wk_page) << fssw_pkg::PAGE_SH;
    remaining = wk_fill - page_base;
    flags.page_last = remaining <= CW'(fssw_pkg::PAGE_BYTES);
    page_cnt  = flags.page_last ? remaining : CW'(fssw_pkg::PAGE_BYTES);
    flags.full      = cur_fill == FW'(fssw_pkg::SECTOR_BYTES - 1);
    flags.fill_zero = cur_fill == '0;
    flags.nodata    = !(cur_total > cur_rtotal);
  end

  // Stage the byte at the current fill position
  always_ff @(posedge clk) begin
    if (fire && op == fssw_pkg::OP_WRITE) begin
      staging_buffer[{rg, cur_fill}] <= byte_q;
    end
  end

  // Request latch and work registers
  always_ff @(posedge clk) begin
    if (fire) begin
      case (op)
        fssw_pkg::OP_LATCH: begin
          rg     <= in_region;
          byte_q <= in_data_byte;
          size_q <= in_stored_size;
        end
        fssw_pkg::OP_WRITE: begin
          wk_fill   <= CW'(fssw_pkg::SECTOR_BYTES);
          wk_sector <= write_sector[rg];
        end
        fssw_pkg::OP_FLUSH: begin
          wk_fill   <= CW'(cur_fill);
          wk_sector <= write_sector[rg];
        end
        fssw_pkg::OP_READ: begin
          wk_count  <= read_cnt;
          wk_sector <= read_sector[rg];
        end
        fssw_pkg::OP_PAGE_CLR: wk_page <= '0;
        fssw_pkg::OP_PAGE_ADV: wk_page <= wk_page + PW'(1);
        default: ;
      endcase
    end
  end

  // Region cursors
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fssw_pkg::REGIONS; i++) begin
        committed_total[i] <= '0;
        write_sector[i]    <= '0;
        buffer_fill[i]     <= '0;
        read_total[i]      <= '0;
        read_sector[i]     <= '0;
      end
    end else if (fire) begin
      case (op)
        fssw_pkg::OP_WRITE: begin
          if (flags.full) begin
            buffer_fill[rg]     <= '0;
            write_sector[rg]    <= write_sector[rg] + SW'(1);
            committed_total[rg] <= cur_total + TW'(fssw_pkg::SECTOR_BYTES);
          end else begin
            buffer_fill[rg] <= cur_fill + FW'(1);
          end
        end
        fssw_pkg::OP_FLUSH: begin
          committed_total[rg] <= cur_total + TW'(cur_fill);
        end
        fssw_pkg::OP_READ: begin
          if (!flags.nodata) begin
            read_total[rg] <= cur_rtotal + TW'(read_cnt);
            if (sector_ahead) begin
              read_sector[rg] <= read_sector[rg] + SW'(1);
            end
          end
        end
        fssw_pkg::OP_SETSIZE: begin
          committed_total[rg] <= size_q;
          buffer_fill[rg]     <= size_q[FW-1:0];
          write_sector[rg]    <= size_q[FW +: SW];
        end
        fssw_pkg::OP_CLEAR: begin
          committed_total[rg] <= '0;
          write_sector[rg]    <= '0;
          buffer_fill[rg]     <= '0;
          read_total[rg]      <= '0;
          read_sector[rg]     <= '0;
        end
        default: ;
      endcase
    end
  end

  // Result register
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && ex.uw.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && ex.uw.emit) begin
      out_cmd          <= ex.uw.cmd;
      out_status       <= ex.uw.status;
      out_region_total <= cur_total;
      case (ex.uw.asel)
        fssw_pkg::ASEL_SECTOR: out_flash_addr <= fssw_pkg::flash_addr(rg, wk_sector, '0);
        fssw_pkg::ASEL_PAGE:
          out_flash_addr <= fssw_pkg::flash_addr(rg, wk_sector, page_base[FW-1:0]);
        default:               out_flash_addr <= '0;
      endcase
      out_buffer_offset <= (ex.uw.asel == fssw_pkg::ASEL_PAGE) ? page_base[FW-1:0] : '0;
      case (ex.uw.csel)
        fssw_pkg::CSEL_READ: out_byte_count <= wk_count;
        fssw_pkg::CSEL_PAGE: out_byte_count <= page_cnt;
        default:             out_byte_count <= '0;
      endcase
      case (ex.uw.lsel)
        fssw_pkg::LAST_YES:  out_last <= 1'b1;
        fssw_pkg::LAST_PAGE: out_last <= flags.page_last;
        default:             out_last <= 1'b0;
      endcase
    end
  end

endmodule

@@ verif/fssw_cmd_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fssw_cmd_checker
// Watches the request and command channels of the flash sector staging writer,
// predicts the flash command stream for every request transfer and compares
// each command transfer against the oldest predicted command.
// ----------------------------------------------------------------------------
module fssw_cmd_checker
  import fssw_pkg::*;
(
  input  logic clk,
  input  logic rst,
  fssw_req_if  req,
  fssw_rsp_if  rsp,
  output int   fail_count,
  output int   pending,
  output int   checked,
  output int   sector_commits,
  output int   empty_reads
);

  typedef struct {
    cmd_t                cmd;
    logic [ADDR_W-1:0]   addr;
    logic [COUNT_W-1:0]  count;
    logic [FILL_W-1:0]   offset;
    logic                status;
    logic [TOTAL_W-1:0]  total;
    logic                last;
  } flash_cmd_t;

  flash_cmd_t expected_cmds[$];

  // Per-region cursors
  logic [TOTAL_W-1:0]  committed [REGIONS];
  logic [SECTOR_W-1:0] wr_sector [REGIONS];
  logic [FILL_W-1:0]   fill      [REGIONS];
  logic [TOTAL_W-1:0]  rd_total  [REGIONS];
  logic [SECTOR_W-1:0] rd_sector [REGIONS];

  function automatic logic [ADDR_W-1:0] region_addr(int unsigned rg, int unsigned sector,
                                                    int unsigned off);
    int unsigned a;
    a = rg * REGION_BYTES + sector * SECTOR_BYTES + off;
    return ADDR_W'(a);
  endfunction

  function automatic void push_cmd(cmd_t c, logic [ADDR_W-1:0] a, int unsigned n,
                                   int unsigned off, logic st, logic [TOTAL_W-1:0] t);
    flash_cmd_t e;
    e.cmd    = c;
    e.addr   = a;
    e.count  = COUNT_W'(n);
    e.offset = FILL_W'(off);
    e.status = st;
    e.total  = t;
    e.last   = 1'b0;
    expected_cmds.push_back(e);
  endfunction

  // Erase, write enable, then page programs; the final page may be short.
  function automatic void push_commit(int unsigned rg, int unsigned sector,
                                      int unsigned nbytes, logic [TOTAL_W-1:0] t);
    int unsigned pg;
    int unsigned left;
    push_cmd(CMD_ERASE, region_addr(rg, sector, 0), 0, 0, 1'b0, t);
    push_cmd(CMD_WREN, '0, 0, 0, 1'b0, t);
    for (pg = 0; pg * PAGE_BYTES < nbytes; pg++) begin
      left = nbytes - pg * PAGE_BYTES;
      push_cmd(CMD_PROG, region_addr(rg, sector, pg * PAGE_BYTES),
               (left > PAGE_BYTES) ? PAGE_BYTES : left, pg * PAGE_BYTES, 1'b0, t);
    end
    sector_commits++;
  endfunction

  function automatic void predict_commands(logic [REQ_W-1:0] kind, logic [REGION_W-1:0] rg,
                                           logic [TOTAL_W-1:0] stored);
    int unsigned f;
    int unsigned n;
    logic [SECTOR_W-1:0] s;
    case (kind)
      REQ_WRITE: begin
        f = fill[rg] + 1;
        if (f >= SECTOR_BYTES) begin
          s             = wr_sector[rg];
          fill[rg]      = '0;
          wr_sector[rg] = s + 1'b1;
          committed[rg] = committed[rg] + TOTAL_W'(SECTOR_BYTES);
          push_commit(rg, s, SECTOR_BYTES, committed[rg]);
        end else begin
          fill[rg] = FILL_W'(f);
          push_cmd(CMD_ACK, '0, 0, 0, 1'b0, committed[rg]);
        end
      end
      REQ_FLUSH: begin
        // fill and sector stay put, so a second flush commits the same bytes again
        if (fill[rg] != '0) begin
          committed[rg] = committed[rg] + TOTAL_W'(fill[rg]);
          push_commit(rg, wr_sector[rg], fill[rg], committed[rg]);
        end else begin
          push_cmd(CMD_ACK, '0, 0, 0, 1'b0, committed[rg]);
        end
      end
      REQ_READ: begin
        if (committed[rg] > rd_total[rg]) begin
          s = rd_sector[rg];
          if (wr_sector[rg] > s) begin
            n             = SECTOR_BYTES;
            rd_sector[rg] = s + 1'b1;
          end else begin
            n = committed[rg] - rd_total[rg];
            if (n > SECTOR_BYTES) n = SECTOR_BYTES;
          end
          rd_total[rg] = rd_total[rg] + TOTAL_W'(n);
          push_cmd(CMD_READ, region_addr(rg, s, 0), n, 0, 1'b0, committed[rg]);
        end else begin
          push_cmd(CMD_ACK, '0, 0, 0, 1'b1, committed[rg]);
          empty_reads++;
        end
      end
      REQ_SETSIZE: begin
        committed[rg] = stored;
        fill[rg]      = stored[FILL_W-1:0];
        wr_sector[rg] = stored[TOTAL_W-1:FILL_W];
        push_cmd(CMD_ACK, '0, 0, 0, 1'b0, committed[rg]);
      end
      REQ_CLEAR: begin
        committed[rg] = '0;
        wr_sector[rg] = '0;
        fill[rg]      = '0;
        rd_total[rg]  = '0;
        rd_sector[rg] = '0;
        push_cmd(CMD_ACK, '0, 0, 0, 1'b0, '0);
      end
      default: begin
        push_cmd(CMD_ACK, '0, 0, 0, 1'b0, committed[rg]);
      end
    endcase
    expected_cmds[expected_cmds.size() - 1].last = 1'b1;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR %0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("command %0d: %s = 0x%0h, expected 0x%0h",
                                checked, name, got, want));
  endtask

  always @(posedge clk) begin : monitor
    flash_cmd_t want;
    if (rst) begin
      for (int r = 0; r < REGIONS; r++) begin
        committed[r] = '0;
        wr_sector[r] = '0;
        fill[r]      = '0;
        rd_total[r]  = '0;
        rd_sector[r] = '0;
      end
      expected_cmds.delete();
      fail_count     = 0;
      pending        = 0;
      checked        = 0;
      sector_commits = 0;
      empty_reads    = 0;
    end else begin
      if (req.valid && req.ready)
        predict_commands(req.req_type, req.region, req.stored_size);
      if (rsp.valid && rsp.ready) begin
        if (expected_cmds.size() == 0) begin
          report_mismatch($sformatf("command %0d: cmd %0d with nothing expected",
                                    checked, rsp.cmd));
        end else begin
          want = expected_cmds.pop_front();
          check_field("cmd", rsp.cmd, want.cmd);
          check_field("flash_addr", rsp.flash_addr, want.addr);
          check_field("byte_count", rsp.byte_count, want.count);
          check_field("buffer_offset", rsp.buffer_offset, want.offset);
          check_field("status", rsp.status, want.status);
          check_field("region_total", rsp.region_total, want.total);
          check_field("last", rsp.last, want.last);
        end
        checked++;
      end
      pending = expected_cmds.size();
    end
  end

endmodule

@@ verif/flash_sector_staging_writer_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flash_sector_staging_writer_tb
// Drives request transfers into the staging writer, takes its flash commands
// with random back-pressure, and lets fssw_cmd_checker predict and compare
// every command. A directed opening covers the corner cases; a random part
// then runs sector fills, partial flushes, reads and raw request noise.
// ----------------------------------------------------------------------------
module flash_sector_staging_writer_tb;
  import fssw_pkg::*;

  localparam int unsigned CLK_HALF     = 10;
  localparam int unsigned IDLE_LIMIT   = 4000;  // cycles without any transfer
  localparam int unsigned HOLD_AT      = 40;    // commands taken before the long hold-off
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned RANDOM_ITEMS = 75;
  localparam int unsigned DRAIN_CYCLES = 24;

  // Request codes the block does not decode; each must still be acknowledged
  localparam logic [REQ_W-1:0] REQ_UNUSED_5 = 3'd5;
  localparam logic [REQ_W-1:0] REQ_UNUSED_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_UNUSED_7 = 3'd7;

  logic clk;
  logic rst;
  int   sent;
  int   fail_count;
  int   pending;
  int   checked;
  int   sector_commits;
  int   empty_reads;

  fssw_req_if req_ch ();
  fssw_rsp_if rsp_ch ();

  flash_sector_staging_writer i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  fssw_cmd_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .req            (req_ch),
    .rsp            (rsp_ch),
    .fail_count     (fail_count),
    .pending        (pending),
    .checked        (checked),
    .sector_commits (sector_commits),
    .empty_reads    (empty_reads)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Hold reset at the start of the run, then release it for good.
  initial begin
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  // Watchdog: stop the run if neither channel moves for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Timeout: no transfer for %0d cycles, %0d commands still due",
             IDLE_LIMIT, pending);
    $display("FAIL flash_sector_staging_writer");
    $finish;
  end

  function automatic logic [BYTE_W-1:0] any_byte();
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [TOTAL_W-1:0] any_size();
    return TOTAL_W'($urandom_range(0, (1 << TOTAL_W) - 1));
  endfunction

  // Offer one request and hold it until the block takes it. Every third block
  // of ten requests goes out back to back so that some stretches carry no gaps.
  // When the previous request was just taken and the gap is zero, valid stays
  // high and only the payload changes.
  task automatic send(logic [REQ_W-1:0] kind, logic [REGION_W-1:0] rg,
                      logic [BYTE_W-1:0] data, logic [TOTAL_W-1:0] stored);
    int gap;
    gap = ((sent % 30) >= 20) ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= kind;
    req_ch.region      <= rg;
    req_ch.data_byte   <= data;
    req_ch.stored_size <= stored;
    do @(posedge clk); while (!req_ch.ready);
    sent++;
  endtask

  // Park the write cursor one to four bytes short of a sector boundary anywhere
  // in the region (top sector included, so the sector counter and the total
  // wrap), then write the missing bytes so the last one commits the sector.
  task automatic fill_and_commit(logic [REGION_W-1:0] rg);
    int unsigned short_by;
    int unsigned stored;
    short_by = $urandom_range(1, 4);
    stored   = $urandom_range(0, (1 << SECTOR_W) - 1) * SECTOR_BYTES + SECTOR_BYTES - short_by;
    send(REQ_SETSIZE, rg, any_byte(), TOTAL_W'(stored));
    repeat (short_by) send(REQ_WRITE, rg, any_byte(), any_size());
    if ($urandom_range(0, 1)) send(REQ_READ, rg, any_byte(), any_size());
  endtask

  // Load an arbitrary size, add up to three bytes, flush the partial sector (once
  // or twice) and read back up to two chunks.
  task automatic partial_flush(logic [REGION_W-1:0] rg);
    send(REQ_SETSIZE, rg, any_byte(), any_size());
    repeat ($urandom_range(0, 3)) send(REQ_WRITE, rg, any_byte(), any_size());
    repeat ($urandom_range(1, 2)) send(REQ_FLUSH, rg, any_byte(), any_size());
    repeat ($urandom_range(0, 2)) send(REQ_READ, rg, any_byte(), any_size());
  endtask

  // Command sink: a random stall before each command, with stall-free
  // stretches, and one long hold-off that backs the block up into its request
  // side while the sender keeps offering.
  initial begin : receiver
    int taken;
    int stall;
    bit held;
    rsp_ch.ready = 1'b0;
    taken        = 0;
    held         = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (!held && taken >= HOLD_AT) begin
        held = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = ((taken % 64) >= 40) ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
      taken++;
    end
  end

  initial begin : stimulus
    int first_random;
    int pick;
    logic [REGION_W-1:0] rg;
    req_ch.valid       = 1'b0;
    req_ch.req_type    = REQ_WRITE;
    req_ch.region      = '0;
    req_ch.data_byte   = '0;
    req_ch.stored_size = '0;
    sent               = 0;
    while (rst !== 1'b0) @(posedge clk);

    // Fresh region: nothing to read, nothing to flush.
    send(REQ_READ, 1'b0, 8'h00, '0);
    send(REQ_FLUSH, 1'b0, 8'h00, '0);
    // Two bytes at the data extremes, then flush the short sector twice; the
    // fill is not cleared, so the second flush adds it to the total again.
    send(REQ_WRITE, 1'b0, 8'h00, '0);
    send(REQ_WRITE, 1'b0, 8'hFF, '1);
    send(REQ_FLUSH, 1'b0, 8'h00, '0);
    send(REQ_FLUSH, 1'b0, 8'h00, '0);
    // Remainder read inside the current sector.
    send(REQ_READ, 1'b0, 8'h00, '0);
    // Region 1: one byte short of a sector, then the byte that commits it.
    send(REQ_SETSIZE, 1'b1, 8'h00, TOTAL_W'(SECTOR_BYTES - 1));
    send(REQ_WRITE, 1'b1, 8'hA5, '0);
    // Whole-sector read, then nothing left.
    send(REQ_READ, 1'b1, 8'h00, '0);
    send(REQ_READ, 1'b1, 8'h00, '0);
    // All-ones size: top sector of region 0; committing it wraps the total
    // and the sector counter.
    send(REQ_SETSIZE, 1'b0, 8'h00, '1);
    send(REQ_WRITE, 1'b0, 8'h5A, '0);
    // Largest meaningful size, then wipe the region.
    send(REQ_SETSIZE, 1'b0, 8'h00, TOTAL_W'(REGION_BYTES));
    send(REQ_CLEAR, 1'b0, 8'h00, '0);
    // Nearly full sector flushed twice without advancing the sector, so the
    // next read's remainder exceeds a sector and gets capped.
    send(REQ_SETSIZE, 1'b0, 8'h00, TOTAL_W'(SECTOR_BYTES - 1));
    send(REQ_FLUSH, 1'b0, 8'h00, '0);
    send(REQ_FLUSH, 1'b0, 8'h00, '0);
    send(REQ_READ, 1'b0, 8'h00, '0);
    // One full page plus a short one.
    send(REQ_SETSIZE, 1'b1, 8'h00, TOTAL_W'(300));
    send(REQ_FLUSH, 1'b1, 8'h00, '0);
    // Undecoded request codes on both regions.
    send(REQ_UNUSED_5, 1'b0, 8'h00, '0);
    send(REQ_UNUSED_6, 1'b1, 8'h00, '0);
    send(REQ_UNUSED_7, 1'b0, 8'h00, '1);
    send(REQ_CLEAR, 1'b1, 8'h00, '0);

    // Random part: mostly well-formed commit and flush sequences, the rest
    // raw requests with every field random.
    first_random = sent;
    while (sent < first_random + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      rg   = REGION_W'($urandom_range(0, 1));
      if (pick < 55)
        fill_and_commit(rg);
      else if (pick < 75)
        partial_flush(rg);
      else
        send(REQ_W'($urandom_range(0, 7)), rg, any_byte(), any_size());
    end
    req_ch.valid <= 1'b0;

    // Drain: wait for every predicted command, then keep the clock running to catch
    // anything the block might still emit.
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run: %0d requests on both regions, %0d flash commands compared",
             sent, checked);
    $display("     %0d sector commits, %0d reads with no data, one long command hold-off",
             sector_commits, empty_reads);
    if (fail_count == 0)
      $display("PASS flash_sector_staging_writer");
    else
      $display("FAIL flash_sector_staging_writer");
    $finish;
  end

endmodule
